/* rtl/core/cle_pkg.sv */
// cle_pkg: shared types and constants of the console line editor.
// Used by cle_ctrl, cle_datapath, console_line_editor and the testbench. No dependencies.
`timescale 1ns / 1ps

package cle_pkg;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  localparam logic DEST_ECHO   = 1'b0;
  localparam logic DEST_READER = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic clear_idx;
    logic emit_echo;
    logic emit_flush;
  } cle_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_echo;
    logic echo_last;
    logic has_flush;
    logic flush_last;
    logic out_free;
  } cle_stat_t;

endpackage

/* rtl/core/cle_ctrl.sv */
// cle_ctrl: sequencer of the console line editor.
// Depends on cle_pkg; drives cle_datapath through cle_cmd_t / cle_stat_t.
`timescale 1ns / 1ps

module cle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cle_pkg::cle_stat_t stat,
  output cle_pkg::cle_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_ECHO,
    S_PREP,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update    = 1'b1;
        cmd.clear_idx = 1'b1;
        state_next    = S_ECHO;
      end
      S_ECHO: begin
        if (!stat.has_echo) begin
          cmd.clear_idx = 1'b1;
          state_next    = stat.has_flush ? S_PREP : S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_echo = 1'b1;
          if (stat.echo_last) begin
            cmd.clear_idx = 1'b1;
            state_next    = stat.has_flush ? S_PREP : S_IDLE;
          end
        end
      end
      S_PREP: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit_flush = 1'b1;
          if (stat.flush_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/cle_datapath.sv */
// cle_datapath: config registers, line store, line length and output register.
// Depends on cle_pkg; commanded by cle_ctrl.
`timescale 1ns / 1ps

module cle_datapath #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [cle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                            cfg_data,
  input  logic [7:0]                      rx_byte,
  input  logic                            chunk_end,
  input  cle_pkg::cle_cmd_t               cmd,
  output cle_pkg::cle_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            destination,
  output logic [7:0]                      out_byte,
  output logic                            last
);

  localparam int LW = $clog2(LINE_DEPTH + 1);
  localparam int IW = $clog2(LINE_DEPTH);

  logic          line_mode;
  logic          echo_enable;
  logic [7:0]    cur_byte;
  logic          cur_end;
  logic [LW-1:0] line_length;
  logic [LW-1:0] flush_count;
  logic [1:0]    echo_count;
  logic [LW-1:0] idx;
  logic [7:0]    line_store [LINE_DEPTH];
  logic [7:0]    rd_data;

  logic          is_ctrl_p;
  logic          is_del;
  logic          is_eol;
  logic          do_store;
  logic          flush_now;
  logic          raw_end;
  logic [LW-1:0] len_inc;
  logic [LW-1:0] len_after;
  logic [LW-1:0] line_length_next;
  logic [LW-1:0] flush_count_next;
  logic [1:0]    echo_count_next;
  logic [IW-1:0] rd_addr;
  logic [7:0]    echo_byte;

  always_comb begin
    is_ctrl_p = (cur_byte == cle_pkg::CH_CTRL_P);
    is_del    = (cur_byte == cle_pkg::CH_DEL);
    is_eol    = (cur_byte == cle_pkg::CH_LF) || (cur_byte == cle_pkg::CH_CR);
    do_store  = !is_ctrl_p && !(line_mode && is_del);
    len_inc   = line_length + LW'(1);
    flush_now = is_eol || (len_inc >= LW'(LINE_DEPTH));
    raw_end   = cur_end && !line_mode;
    if (do_store) begin
      len_after = flush_now ? '0 : len_inc;
    end else if (!is_ctrl_p && (line_length != '0)) begin
      len_after = line_length - LW'(1);
    end else begin
      len_after = line_length;
    end
    if (do_store && flush_now) begin
      flush_count_next = len_inc;
    end else if (raw_end) begin
      flush_count_next = len_after;
    end else begin
      flush_count_next = '0;
    end
    line_length_next = raw_end ? '0 : len_after;
    if (is_ctrl_p || !echo_enable) begin
      echo_count_next = 2'd0;
    end else if (is_del) begin
      echo_count_next = 2'd3;
    end else begin
      echo_count_next = 2'd1;
    end
  end

  always_comb begin
    if (is_del) begin
      echo_byte = (idx == LW'(1)) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
    end else begin
      echo_byte = cur_byte;
    end
    rd_addr = cmd.emit_flush ? (idx[IW-1:0] + IW'(1)) : idx[IW-1:0];
  end

  assign stat.has_echo   = (echo_count != 2'd0);
  assign stat.echo_last  = (idx == (LW'(echo_count) - LW'(1)));
  assign stat.has_flush  = (flush_count != '0);
  assign stat.flush_last = (idx == (flush_count - LW'(1)));
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.update && do_store) begin
      line_store[line_length[IW-1:0]] <= cur_byte;
    end
    rd_data <= line_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode   <= 1'b0;
      echo_enable <= 1'b1;
      line_length <= '0;
      flush_count <= '0;
      echo_count  <= 2'd0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          cle_pkg::REG_LINE_MODE:   line_mode   <= cfg_data;
          cle_pkg::REG_ECHO_ENABLE: echo_enable <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.update) begin
        line_length <= line_length_next;
        flush_count <= flush_count_next;
        echo_count  <= echo_count_next;
      end
      if (cmd.clear_idx) begin
        idx <= '0;
      end else if (cmd.emit_echo || cmd.emit_flush) begin
        idx <= idx + LW'(1);
      end
      if (cmd.emit_echo || cmd.emit_flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_byte <= rx_byte;
      cur_end  <= chunk_end;
    end
    if (cmd.emit_echo) begin
      destination <= cle_pkg::DEST_ECHO;
      out_byte    <= echo_byte;
      last        <= stat.echo_last && !stat.has_flush;
    end else if (cmd.emit_flush) begin
      destination <= cle_pkg::DEST_READER;
      out_byte    <= rd_data;
      last        <= stat.flush_last;
    end
  end

`ifndef SYNTHESIS
  a_len_below_depth: assert property (@(posedge clk) disable iff (rst)
    line_length < LW'(LINE_DEPTH))
    else $error("line length reached depth without flush");

  a_flush_clears_line: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (flush_count == '0) || (line_length == '0))
    else $error("flush left bytes in line store");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_echo || cmd.emit_flush) |-> stat.out_free)
    else $error("output word overwritten");

  a_flush_needs_bytes: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_flush |-> stat.has_flush)
    else $error("flush emit with empty flush count");
`endif

endmodule

/* rtl/core/console_line_editor.sv */
// console_line_editor: top level of the console input line editor.
// Depends on cle_pkg, cle_ctrl and cle_datapath.
//
//   channel  signals                                   direction
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in (always ready)
//   in       in_valid/in_ready, rx_byte, chunk_end     in
//   out      out_valid/out_ready, destination,         out
//            out_byte, last
//
// A byte passes through capture (S_IDLE), S_UPDATE and S_ECHO, which emits no echo word, one, or three (DEL).
// A line flush adds S_PREP for the store read setup, then S_FLUSH emits one word per stored byte.
// Intake is closed from acceptance until the last word is loaded in the output register.
// A stalled output holds the sequencer; reset clears the line length, sets raw mode, echo on.
`timescale 1ns / 1ps

module console_line_editor #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  input  logic                          chunk_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          destination,
  output logic [7:0]                    out_byte,
  output logic                          last
);

  cle_pkg::cle_cmd_t  cmd;
  cle_pkg::cle_stat_t stat;

  assign cfg_ready = 1'b1;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cle_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx_byte     (rx_byte),
    .chunk_end   (chunk_end),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .destination (destination),
    .out_byte    (out_byte),
    .last        (last)
  );

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for console_line_editor (echo, line editing, flushes).
// Depends on cle_pkg and the console_line_editor RTL; drives directed and random bytes,
// predicts every output word and checks it in order under random backpressure.
`timescale 1ns / 1ps

module testbench;

  localparam int LINE_DEPTH  = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 48;
  localparam int CFG_SETTLE  = 10;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic                          clk;
  logic                          rst         = 1'b1;
  logic                          cfg_valid   = 1'b0;
  logic                          cfg_ready;
  logic [cle_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic                          cfg_data    = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic [7:0]                    rx_byte     = 8'h00;
  logic                          chunk_end   = 1'b0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic                          destination;
  logic [7:0]                    out_byte;
  logic                          last;

  // predictor state
  logic [7:0] line_buf [LINE_DEPTH];
  int         pend_count = 0;
  logic       mode_line  = 1'b0;
  logic       echo_on    = 1'b1;
  out_word_t  expected_q [$];

  int err_count     = 0;
  int items_sent    = 0;
  int words_checked = 0;
  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  int stall_seq     = 0;
  int stall_seen    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  console_line_editor #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .chunk_end(chunk_end),
    .out_valid(out_valid), .out_ready(out_ready), .destination(destination),
    .out_byte(out_byte), .last(last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void push_word(logic dest, logic [7:0] data);
    out_word_t w;
    w.dest = dest;
    w.data = data;
    w.last = 1'b0;
    expected_q.push_back(w);
  endfunction

  function automatic void flush_line_words();
    for (int i = 0; i < pend_count; i++) push_word(cle_pkg::DEST_READER, line_buf[i]);
    pend_count = 0;
  endfunction

  function automatic void predict_words(logic [7:0] b, logic ce);
    int before_n;
    before_n = expected_q.size();
    if (b != cle_pkg::CH_CTRL_P) begin
      if (echo_on) begin
        if (b == cle_pkg::CH_DEL) begin
          push_word(cle_pkg::DEST_ECHO, cle_pkg::CH_BS);
          push_word(cle_pkg::DEST_ECHO, cle_pkg::CH_SPACE);
          push_word(cle_pkg::DEST_ECHO, cle_pkg::CH_BS);
        end else begin
          push_word(cle_pkg::DEST_ECHO, b);
        end
      end
      if (mode_line && b == cle_pkg::CH_DEL) begin
        if (pend_count != 0) pend_count--;
      end else begin
        if (pend_count < LINE_DEPTH) line_buf[pend_count] = b;
        pend_count++;
        if (b == cle_pkg::CH_LF || b == cle_pkg::CH_CR) flush_line_words();
        if (pend_count >= LINE_DEPTH) flush_line_words();
      end
    end
    if (ce && !mode_line) flush_line_words();
    if (expected_q.size() > before_n) expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  // sender: called at a rising edge; returns at the edge that accepted the word
  task automatic send_word(input logic [7:0] b, input logic ce);
    logic acc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    chunk_end <= ce;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    predict_words(b, ce);
    items_sent++;
  endtask

  task automatic write_reg(input logic [cle_pkg::CFG_IDX_W-1:0] idx, input logic val);
    logic acc;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    if (idx == cle_pkg::REG_LINE_MODE) mode_line = val;
    else echo_on = val;
  endtask

  // receiver ready, with an occasional long hold-off
  always @(posedge clk) begin
    if (stall_seq != stall_seen) begin
      stall_seen <= stall_seq;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // output checker; inputs only change at rising edges, so the falling edge sees the handshake
  always @(negedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected word: destination %0d out_byte %02h last %0d",
               destination, out_byte, last);
        err_count++;
      end else begin
        exp_w = expected_q.pop_front();
        if (destination !== exp_w.dest) begin
          $error("destination: expected %0d, actual %0d", exp_w.dest, destination);
          err_count++;
        end
        if (out_byte !== exp_w.data) begin
          $error("out_byte: expected %02h, actual %02h", exp_w.data, out_byte);
          err_count++;
        end
        if (last !== exp_w.last) begin
          $error("last: expected %0d, actual %0d", exp_w.last, last);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_raw_mode();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(cle_pkg::CH_CTRL_P, 1'b1);
    send_word("a", 1'b0);
    send_word(cle_pkg::CH_CTRL_P, 1'b1);
    send_word(cle_pkg::CH_DEL, 1'b0);
    send_word(cle_pkg::CH_CR, 1'b0);
  endtask

  task automatic test_line_editing();
    write_reg(cle_pkg::REG_LINE_MODE, 1'b1);
    send_word("h", 1'b0);
    send_word("i", 1'b0);
    send_word(cle_pkg::CH_DEL, 1'b0);
    send_word(cle_pkg::CH_DEL, 1'b0);
    send_word(cle_pkg::CH_DEL, 1'b0);
    send_word("o", 1'b0);
    send_word("k", 1'b1);
    send_word(cle_pkg::CH_LF, 1'b0);
    send_word(cle_pkg::CH_CTRL_P, 1'b0);
    send_word("z", 1'b0);
    send_word(cle_pkg::CH_CR, 1'b1);
  endtask

  task automatic test_echo_off_mode_switch();
    write_reg(cle_pkg::REG_ECHO_ENABLE, 1'b0);
    send_word("q", 1'b0);
    send_word("r", 1'b0);
    write_reg(cle_pkg::REG_LINE_MODE, 1'b0);
    send_word("s", 1'b1);
    send_word(cle_pkg::CH_CTRL_P, 1'b0);
    write_reg(cle_pkg::REG_ECHO_ENABLE, 1'b1);
  endtask

  task automatic test_backpressure();
    write_reg(cle_pkg::REG_LINE_MODE, 1'b1);
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    @(negedge clk);
    stall_seq = stall_seq + 1;
    @(posedge clk);
    for (int i = 0; i < 24; i++)
      send_word((i % 8 == 7) ? cle_pkg::CH_CR : 8'($urandom_range(8'h21, 8'h7E)), 1'b0);
  endtask

  task automatic run_random_lines(input int n_items);
    int         start_n;
    int         len;
    int         r;
    logic [7:0] b;
    start_n = items_sent;
    while (items_sent - start_n < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        len = ($urandom_range(5) == 0) ? int'($urandom_range(30, 40))
                                       : int'($urandom_range(0, 12));
        for (int j = 0; j < len && items_sent - start_n < n_items; j++) begin
          r = int'($urandom_range(99));
          if (r < 70) b = 8'($urandom_range(8'h20, 8'h7E));
          else if (r < 80) b = cle_pkg::CH_DEL;
          else if (r < 85) b = cle_pkg::CH_CTRL_P;
          else b = 8'($urandom_range(255));
          send_word(b, ($urandom_range(15) == 0));
        end
        send_word($urandom_range(1) ? cle_pkg::CH_CR : cle_pkg::CH_LF, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 63 : 0;
      rcv_idle_pct  = (phase == 0) ? 63 : (phase == 1) ? 8 : 0;
      for (int combo = 0; combo < 4; combo++) begin
        write_reg(cle_pkg::REG_LINE_MODE, (combo == 1 || combo == 2));
        write_reg(cle_pkg::REG_ECHO_ENABLE, (combo < 2));
        run_random_lines(27);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_raw_mode();
    test_line_editing();
    test_echo_off_mode_switch();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected words never arrived", expected_q.size());
      err_count++;
    end
    $display("covered raw and line modes, echo on/off, DEL editing, control-P, full-store");
    $display("flushes and a long output stall: %0d bytes in, %0d words checked",
             items_sent, words_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/cle_pkg.sv
rtl/core/cle_ctrl.sv
rtl/core/cle_datapath.sv
rtl/core/console_line_editor.sv
tb/sv/testbench.sv
